// ----- src/hrde_pkg.sv -----
// Shared types, codes and helpers for the hex record data extractor.
// Used by the front, queue, back and checker modules; no dependencies.
package hrde_pkg;

  localparam int unsigned PosW          = 10;
  localparam int unsigned DataStart     = 9;
  localparam int unsigned HdrFirst      = 9;
  localparam int unsigned HdrLast       = 12;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharLf = 8'd10;

  typedef enum logic [2:0] {
    OP_HDR_DIGIT,
    OP_HDR_LAST,
    OP_DATA_HI,
    OP_DATA_LO,
    OP_END_DATA,
    OP_BAD_LEN
  } hrde_op_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_END   = 2'd2,
    KIND_BAD   = 2'd3
  } hrde_kind_e;

  typedef struct packed {
    hrde_op_e   op;
    logic [3:0] nibble;
  } hrde_cmd_t;

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c inside {[8'd97:8'd102]}) u = c & 8'h5F;
    if (u inside {[8'd65:8'd70]}) return 4'(u - 8'd55);
    if (u inside {[8'd48:8'd57]}) return 4'(u - 8'd48);
    return 4'd0;
  endfunction

endpackage

// ----- src/hex_record_data_extractor_unit.sv -----
// Top level of the hex record data extractor: front, queue and back end.
// Depends on hrde_pkg, hrde_front, hrde_queue and hrde_back.
//
// Accepts one character per clock cycle, every cycle, as long as the command
// queue (QueueDepth beats) has room. For a character that causes a result,
// the front classifies it combinationally and writes a command into the
// queue, and the back end then moves the queue head into the output
// register whenever that register is empty or not stalled.
// The output register holds a result while out_stall_i is high, and the
// queue absorbs characters meanwhile.
// After end of data or a bad record length no further results come until
// reset; characters keep being accepted and dropped.
module hex_record_data_extractor_unit
  import hrde_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  ascii_char_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] start_address_o
);

  logic      push, full, pop, head_valid;
  hrde_cmd_t push_cmd, head_cmd;

  hrde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .ascii_char_i (ascii_char_i),
    .in_stall_o   (in_stall_o),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  hrde_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  hrde_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_cmd_i      (head_cmd),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .start_address_o (start_address_o)
  );

endmodule

// ----- src/hrde_front.sv -----
// Front end: accepts characters, tracks line position and record length,
// and turns selected characters into commands for the back end. Uses hrde_pkg.
module hrde_front
  import hrde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic [7:0] ascii_char_i,
  output logic      in_stall_o,
  input  logic      full_i,
  output logic      push_o,
  output hrde_cmd_t cmd_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic            cr_q, cr_d;
  logic            hdr_q, hdr_d;
  logic            accept;
  logic [3:0]      nib;
  logic [PosW:0]   win_end;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign nib        = hex_nibble(ascii_char_i);
  assign win_end    = (PosW+1)'(DataStart) + (PosW+1)'({len_q, 1'b0});

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    cr_d   = cr_q;
    hdr_d  = hdr_q;
    push_o = 1'b0;
    cmd_o  = '{op: OP_HDR_DIGIT, nibble: nib};
    if (accept) begin
      if (cr_q && ascii_char_i == CharLf) begin
        pos_d = '0;
        len_d = '0;
        cr_d  = 1'b0;
        hdr_d = 1'b0;
        if (!hdr_q) begin
          if (len_q == 8'd0) begin
            push_o   = 1'b1;
            cmd_o.op = OP_END_DATA;
          end else if (len_q == 8'd1 || len_q == 8'd3) begin
            push_o   = 1'b1;
            cmd_o.op = OP_BAD_LEN;
          end
        end
      end else begin
        cr_d = (ascii_char_i == CharCr);
        if (pos_q != '1) pos_d = pos_q + 1'b1;
        if (hdr_q) begin
          if (pos_q >= PosW'(HdrFirst) && pos_q <= PosW'(HdrLast)) begin
            push_o   = 1'b1;
            cmd_o.op = (pos_q == PosW'(HdrLast)) ? OP_HDR_LAST : OP_HDR_DIGIT;
          end
        end else if (pos_q == PosW'(1)) begin
          len_d = {nib, 4'd0};
        end else if (pos_q == PosW'(2)) begin
          len_d = len_q | {4'd0, nib};
        end else if (pos_q >= PosW'(DataStart) && len_q > 8'd4 &&
                     {1'b0, pos_q} < win_end) begin
          push_o   = 1'b1;
          cmd_o.op = pos_q[0] ? OP_DATA_HI : OP_DATA_LO;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      cr_q  <= 1'b0;
      hdr_q <= 1'b1;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      cr_q  <= cr_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

// ----- src/hrde_queue.sv -----
// Command queue between front and back ends, Depth entries deep.
// Uses hrde_pkg for the command type.
module hrde_queue
  import hrde_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hrde_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output hrde_cmd_t head_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hrde_cmd_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!push_i && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/hrde_back.sv -----
// Back end: executes queued commands, assembles header word and data bytes,
// halts after end of data or bad length, and drives the result register.
module hrde_back
  import hrde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  hrde_cmd_t   head_cmd_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] start_address_o
);

  logic        halted_q, halted_d;
  logic [15:0] hw_q, hw_d;
  logic [3:0]  hn_q, hn_d;
  logic        vld_q, vld_d;
  hrde_kind_e  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] addr_q, addr_d;
  logic        load;

  assign pop_o = head_valid_i && (!vld_q || !out_stall_i);

  always_comb begin
    halted_d = halted_q;
    hw_d     = hw_q;
    hn_d     = hn_q;
    kind_d   = kind_q;
    byte_d   = byte_q;
    addr_d   = addr_q;
    load     = 1'b0;
    if (pop_o && !halted_q) begin
      case (head_cmd_i.op)
        OP_HDR_DIGIT: hw_d = {hw_q[11:0], head_cmd_i.nibble};
        OP_HDR_LAST: begin
          hw_d   = {hw_q[11:0], head_cmd_i.nibble};
          load   = 1'b1;
          kind_d = KIND_ADDR;
          byte_d = '0;
          addr_d = {hw_q[11:0], head_cmd_i.nibble, 16'd0};
        end
        OP_DATA_HI: hn_d = head_cmd_i.nibble;
        OP_DATA_LO: begin
          load   = 1'b1;
          kind_d = KIND_DATA;
          byte_d = {hn_q, head_cmd_i.nibble};
          addr_d = '0;
        end
        OP_END_DATA: begin
          halted_d = 1'b1;
          load     = 1'b1;
          kind_d   = KIND_END;
          byte_d   = '0;
          addr_d   = '0;
        end
        OP_BAD_LEN: begin
          halted_d = 1'b1;
          load     = 1'b1;
          kind_d   = KIND_BAD;
          byte_d   = '0;
          addr_d   = '0;
        end
        default: ;
      endcase
    end
    if (load) vld_d = 1'b1;
    else if (!out_stall_i) vld_d = 1'b0;
    else vld_d = vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      hw_q     <= '0;
      hn_q     <= '0;
      vld_q    <= 1'b0;
    end else begin
      halted_q <= halted_d;
      hw_q     <= hw_d;
      hn_q     <= hn_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    addr_q <= addr_d;
  end

  assign out_valid_o     = vld_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = byte_q;
  assign start_address_o = addr_q;

endmodule

// ----- src/hrde_checker.sv -----
// Port-level checks for the hex record data extractor, bound to the top.
// Depends on hrde_pkg and hex_record_data_extractor_unit.
module hrde_checker
  import hrde_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic [31:0] start_address_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(data_byte_o) && $stable(start_address_o))
    else $error("result changed while stalled");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DATA |-> start_address_o == 32'd0)
    else $error("data beat carries an address");

  a_addr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ADDR |-> data_byte_o == 8'd0 &&
      start_address_o[15:0] == 16'd0)
    else $error("address beat malformed");

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == KIND_END || kind_o == KIND_BAD)
      |=> !out_valid_o)
    else $error("result after halt");

endmodule

bind hex_record_data_extractor_unit hrde_checker u_hrde_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .data_byte_o     (data_byte_o),
  .start_address_o (start_address_o)
);

// ----- tb/hex_record_data_extractor_unit_test.sv -----
// Self-checking testbench for hex_record_data_extractor_unit: drives hex-record text one
// character per beat and checks every result beat against an in-bench decoder model.
// Depends on hrde_pkg and the hex_record_data_extractor_unit RTL.
`timescale 1ns / 100ps

module hex_record_data_extractor_unit_test;
  import hrde_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomChars = 450;
  localparam logic [9:0]  PosTop      = 10'h3FF;

  typedef struct {
    hrde_kind_e  kind;
    logic [7:0]  data_byte;
    logic [31:0] start_address;
  } hex_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  ascii_char_i = 8'h00;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [31:0] start_address_o;

  hex_record_data_extractor_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .ascii_char_i   (ascii_char_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .start_address_o(start_address_o)
  );

  // decoder model state
  logic [9:0]  col_pos = '0;
  logic [7:0]  rec_len = '0;
  logic [3:0]  hi_nib = '0;
  logic        saw_cr = 1'b0;
  logic        header_active = 1'b1;
  logic        stream_done = 1'b0;
  logic [15:0] hdr_word = '0;

  hex_result_t pending_results[$];
  int          mismatch_count = 0;
  int          chars_sent = 0;
  int          lines_sent = 0;
  int          cycle_count = 0;
  int          kind_seen[4] = '{0, 0, 0, 0};
  logic [7:0]  last_char = 8'h00;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= out_idle_on && ($urandom_range(99) < 12);
  end

  function automatic logic [3:0] char_to_nibble(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return 4'(ch - "0");
    if (ch >= "A" && ch <= "F") return 4'(ch - "A" + 8'd10);
    if (ch >= "a" && ch <= "f") return 4'(ch - "a" + 8'd10);
    return 4'h0;
  endfunction

  function automatic logic [7:0] nibble_to_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + 8'(n);
    return (lower ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    // keep a stray CR LF from cutting the line short
    if (b == CharLf && last_char == CharCr) b = "A";
    return b;
  endfunction

  task automatic decode_char(input logic [7:0] ch);
    logic [9:0] pos;
    logic [3:0] nib;
    int         off;
    if (stream_done) return;
    if (saw_cr && ch == CharLf) begin
      if (!header_active && rec_len inside {8'd0, 8'd1, 8'd3}) begin
        pending_results.push_back(hex_result_t'{(rec_len == 8'd0) ? KIND_END : KIND_BAD,
                                                8'h00, 32'h0});
        stream_done = 1'b1;
      end
      saw_cr = 1'b0;
      col_pos = '0;
      rec_len = '0;
      hi_nib = '0;
      header_active = 1'b0;
      return;
    end
    saw_cr = (ch == CharCr);
    pos = col_pos;
    if (col_pos != PosTop) col_pos = col_pos + 10'd1;
    nib = char_to_nibble(ch);
    if (header_active) begin
      if (pos >= HdrFirst && pos <= HdrLast) begin
        hdr_word = {hdr_word[11:0], nib};
        if (pos == HdrLast)
          pending_results.push_back(hex_result_t'{KIND_ADDR, 8'h00, {hdr_word, 16'h0000}});
      end
    end else if (pos == 10'd1) begin
      rec_len = {nib, 4'h0};
    end else if (pos == 10'd2) begin
      rec_len = rec_len | {4'h0, nib};
    end else if (pos >= DataStart && rec_len > 8'd4 && int'(pos) < DataStart + 2 * rec_len) begin
      off = int'(pos) - DataStart;
      if (off % 2 == 0) hi_nib = nib;
      else pending_results.push_back(hex_result_t'{KIND_DATA, {hi_nib, nib}, 32'h0});
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 20)
      $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    hex_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", 32'(kind_o), 32'h0);
      end else begin
        want = pending_results.pop_front();
        kind_seen[want.kind]++;
        if (kind_o !== want.kind) report_mismatch("kind", 32'(kind_o), 32'(want.kind));
        if (data_byte_o !== want.data_byte)
          report_mismatch("data_byte", 32'(data_byte_o), 32'(want.data_byte));
        if (start_address_o !== want.start_address)
          report_mismatch("start_address", start_address_o, want.start_address);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch);
    if (in_idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ascii_char_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_char(ch);
    last_char = ch;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_digit(input logic [3:0] n);
    send_char(nibble_to_char(n, $urandom_range(1)));
  endtask

  task automatic end_line();
    send_char(CharCr);
    send_char(CharLf);
    lines_sent++;
  endtask

  task automatic send_field_char(input bit noisy);
    if (noisy && $urandom_range(19) == 0) send_char(noise_byte());
    else send_digit(4'($urandom_range(15)));
  endtask

  task automatic send_record(input logic [7:0] len_code, input int n_bytes, input bit noisy,
                             input bit junk_hi, input int tail);
    send_char(":");
    if (junk_hi) send_char(8'($urandom_range(255, 128)));
    else send_digit(len_code[7:4]);
    send_digit(len_code[3:0]);
    repeat (6) send_field_char(noisy);
    repeat (2 * n_bytes) send_field_char(noisy);
    repeat (tail) send_digit(4'($urandom_range(15)));
    end_line();
  endtask

  task automatic test_header_line();
    int mode;
    mode = $urandom_range(3);
    send_text(":020000");
    if (mode == 0) begin
      // header cut short before its address digits
      end_line();
    end else begin
      send_text("04");
      for (int i = 0; i < 4; i++)
        send_digit((mode == 1) ? 4'h0 : (mode == 2) ? 4'hF : 4'($urandom_range(15)));
      send_text("F9");
      end_line();
    end
  endtask

  task automatic test_directed_data();
    send_text(":05000000");
    send_text("00fF");
    send_char(CharLf);
    send_char("5");
    send_char(CharCr);
    send_char("9");
    send_char(8'hE7);
    send_char("z");
    send_text("AB");
    end_line();
  endtask

  task automatic test_silent_lengths();
    send_text(":02000000ABcd12");
    end_line();
    send_text(":0400000011223344aa");
    end_line();
  endtask

  task automatic test_random_records();
    int         first_char;
    int         n;
    bit         quiet;
    logic [7:0] len;
    first_char = chars_sent;
    while (chars_sent - first_char < RandomChars) begin
      quiet = (chars_sent - first_char >= 150) && (chars_sent - first_char < 350);
      in_idle_on = !quiet;
      out_idle_on = !quiet;
      case ($urandom_range(9))
        0: len = 8'd2;
        1: len = 8'd4;
        default: len = 8'($urandom_range(24, 5));
      endcase
      n = len;
      case ($urandom_range(7))
        0: n = $urandom_range(len - 1);
        1: n = len + $urandom_range(3, 1);
        default: ;
      endcase
      send_record(len, n, $urandom_range(3) == 0, (len < 8'd16) && ($urandom_range(7) == 0), 2);
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_long_line();
    // long record with digits running past its data window
    send_record(8'h80, 128, 1'b0, 1'b0, 8);
  endtask

  task automatic test_stream_end();
    case ($urandom_range(3))
      0: send_record(8'h00, 0, 1'b0, 1'b0, 2);
      1: end_line();
      2: send_record(8'h01, 1, 1'b0, 1'b0, 2);
      default: send_record(8'h03, 3, 1'b0, 1'b0, 2);
    endcase
    repeat (20) send_char(noise_byte());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_line();
    test_directed_data();
    test_silent_lengths();
    test_random_records();
    test_long_line();
    test_stream_end();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d characters over %0d lines; checked %0d data bytes, %0d start addresses,",
             chars_sent, lines_sent, kind_seen[KIND_DATA], kind_seen[KIND_ADDR]);
    $display("%0d end-of-data and %0d bad-length terminations, %0d mismatches",
             kind_seen[KIND_END], kind_seen[KIND_BAD], mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
